[rtl/c8ic_pkg.sv]
package c8ic_pkg;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_MISC,
    S_FETCH_HI,
    S_FETCH_LO,
    S_DECODE,
    S_OPB,
    S_EXEC,
    S_DRAW_RD,
    S_DRAW_WR,
    S_BCD,
    S_STORE,
    S_LOAD_RD,
    S_LOAD_WR,
    S_FIN,
    S_RESP
  } state_t;

  localparam logic [2:0] REQ_EXEC = 3'd0;
  localparam logic [2:0] REQ_TICK = 3'd1;
  localparam logic [2:0] REQ_KEY  = 3'd2;
  localparam logic [2:0] REQ_LOAD = 3'd3;
  localparam logic [2:0] REQ_ROW  = 3'd4;

  localparam logic [2:0] ST_OK     = 3'd0;
  localparam logic [2:0] ST_WAIT   = 3'd1;
  localparam logic [2:0] ST_NOIMPL = 3'd2;
  localparam logic [2:0] ST_STACK  = 3'd3;
  localparam logic [2:0] ST_HALT   = 3'd4;

  localparam logic [3:0] OPC_SYS  = 4'h0;
  localparam logic [3:0] OPC_JP   = 4'h1;
  localparam logic [3:0] OPC_CALL = 4'h2;
  localparam logic [3:0] OPC_SE   = 4'h3;
  localparam logic [3:0] OPC_SNE  = 4'h4;
  localparam logic [3:0] OPC_LDK  = 4'h6;
  localparam logic [3:0] OPC_ADDK = 4'h7;
  localparam logic [3:0] OPC_ALU  = 4'h8;
  localparam logic [3:0] OPC_LDI  = 4'hA;
  localparam logic [3:0] OPC_RND  = 4'hC;
  localparam logic [3:0] OPC_DRW  = 4'hD;
  localparam logic [3:0] OPC_KEY  = 4'hE;
  localparam logic [3:0] OPC_MISC = 4'hF;

  localparam logic [3:0] ALU_LD  = 4'h0;
  localparam logic [3:0] ALU_AND = 4'h2;
  localparam logic [3:0] ALU_XOR = 4'h3;
  localparam logic [3:0] ALU_ADD = 4'h4;
  localparam logic [3:0] ALU_SUB = 4'h5;
  localparam logic [3:0] ALU_SHL = 4'hE;

  localparam logic [15:0] OP_CLS = 16'h00E0;
  localparam logic [15:0] OP_RET = 16'h00EE;

  localparam logic [7:0] KK_SKP  = 8'h9E;
  localparam logic [7:0] KK_SKNP = 8'hA1;
  localparam logic [7:0] KK_GDLY = 8'h07;
  localparam logic [7:0] KK_WKEY = 8'h0A;
  localparam logic [7:0] KK_SDLY = 8'h15;
  localparam logic [7:0] KK_SND  = 8'h18;
  localparam logic [7:0] KK_ADDI = 8'h1E;
  localparam logic [7:0] KK_FONT = 8'h29;
  localparam logic [7:0] KK_BCD  = 8'h33;
  localparam logic [7:0] KK_STR  = 8'h55;
  localparam logic [7:0] KK_LDR  = 8'h65;

  localparam int FONT_BYTES = 80;

  localparam logic [7:0] FONT_ROM [0:FONT_BYTES-1] = '{
    8'hF0, 8'h90, 8'h90, 8'h90, 8'hF0, 8'h20, 8'h60, 8'h20, 8'h20, 8'h70,
    8'hF0, 8'h10, 8'hF0, 8'h80, 8'hF0, 8'hF0, 8'h10, 8'hF0, 8'h10, 8'hF0,
    8'h90, 8'h90, 8'hF0, 8'h10, 8'h10, 8'hF0, 8'h80, 8'hF0, 8'h10, 8'hF0,
    8'hF0, 8'h80, 8'hF0, 8'h90, 8'hF0, 8'hF0, 8'h10, 8'h20, 8'h40, 8'h40,
    8'hF0, 8'h90, 8'hF0, 8'h90, 8'hF0, 8'hF0, 8'h90, 8'hF0, 8'h10, 8'hF0,
    8'hF0, 8'h90, 8'hF0, 8'h90, 8'h90, 8'hE0, 8'h90, 8'hE0, 8'h90, 8'hE0,
    8'hF0, 8'h80, 8'h80, 8'h80, 8'hF0, 8'hE0, 8'h90, 8'h90, 8'h90, 8'hE0,
    8'hF0, 8'h80, 8'hF0, 8'h80, 8'hF0, 8'hF0, 8'h80, 8'hF0, 8'h80, 8'h80
  };

  function automatic logic [7:0] font_byte(input logic [11:0] addr);
    logic [7:0] res;
    res = 8'd0;
    if (addr < 12'(FONT_BYTES)) begin
      res = FONT_ROM[addr[6:0]];
    end
    return res;
  endfunction

endpackage

[rtl/c8ic_ram.sv]
module c8ic_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [0:DEPTH-1];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

[rtl/chip8_instruction_core.sv]
// Channel  Direction  Transfer when             Payload
// in_      slave      in_tvalid & in_tready     tuser: request kind; tdata: key, load, random, row
// out_     master     out_tvalid & out_tready   tdata: pc, opcode, status, row bits, delay
//
// An execute item fetches both opcode bytes, decodes, reads the operands and executes;
// a draw then reads and writes each visible sprite row, BCD writes three digits, a register
// store writes and a register load reads then writes V0..Vx in turn. Other items are handled
// in the request state. The single-port program memory and framebuffer set these steps.
// After reset all 4096 program memory addresses are swept to load the font; in_tready stays
// low meanwhile. A stalled result holds the sequencer in its result state until the transfer.
module chip8_instruction_core (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [2:0]   in_tuser,   // req_type
  input  logic [39:0]  in_tdata,   // key_index, key_down, load_address, load_byte,
                                   // random_byte, fb_row, zero pad
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [103:0] out_tdata   // pc, opcode, status, fb_row_bits, delay_value,
                                   // zero pad
);

  c8ic_pkg::state_t state_r, state_nxt;

  logic [11:0] clr_r, clr_nxt;
  logic [7:0]  v_r [0:15];
  logic [7:0]  v_nxt [0:15];
  logic [11:0] stk_r [0:15];
  logic [11:0] stk_nxt [0:15];
  logic [15:0] i_r, i_nxt;
  logic [11:0] pc_r, pc_nxt;
  logic [4:0]  depth_r, depth_nxt;
  logic [7:0]  dly_r, dly_nxt;
  logic [15:0] keys_r, keys_nxt;
  logic        wait_r, wait_nxt;
  logic [3:0]  wtgt_r, wtgt_nxt;
  logic        halt_r, halt_nxt;
  logic [31:0] rowv_r, rowv_nxt;
  logic [15:0] op_r, op_nxt;
  logic [7:0]  a_r, a_nxt;
  logic [7:0]  b_r, b_nxt;
  logic [3:0]  cnt_r, cnt_nxt;
  logic [2:0]  st_r, st_nxt;
  logic [2:0]  adv_r, adv_nxt;
  logic        exec_r, exec_nxt;
  logic [2:0]  req_r, req_nxt;
  logic [3:0]  key_r, key_nxt;
  logic        down_r, down_nxt;
  logic [11:0] ldaddr_r, ldaddr_nxt;
  logic [7:0]  ldbyte_r, ldbyte_nxt;
  logic [7:0]  rnd_r, rnd_nxt;
  logic [4:0]  row_r, row_nxt;
  logic        out_v_r, out_v_nxt;
  logic [103:0] out_d_r, out_d_nxt;

  logic        mem_we, mem_re;
  logic [11:0] mem_waddr, mem_raddr;
  logic [7:0]  mem_wdata, mem_rdata;
  logic        fb_we, fb_re;
  logic [4:0]  fb_waddr, fb_raddr;
  logic [63:0] fb_wdata, fb_rdata;

  logic [3:0]  op_x, op_y, op_n;
  logic [7:0]  op_kk;
  logic [4:0]  depth_dec;
  logic [11:0] i_off;
  logic [5:0]  draw_y;
  logic [63:0] draw_mask, draw_old;
  logic [8:0]  sum9;
  logic [15:0] bcd_prod;
  logic [7:0]  bcd_h, bcd_rem;
  logic        in_exec;
  logic [63:0] row_bits;
  logic [2:0]  resp_st;

  assign op_x      = op_r[11:8];
  assign op_y      = op_r[7:4];
  assign op_n      = op_r[3:0];
  assign op_kk     = op_r[7:0];
  assign depth_dec = depth_r - 5'd1;
  assign i_off     = i_r[11:0] + {8'd0, cnt_r};
  assign draw_y    = {1'b0, b_r[4:0]} + {2'b0, cnt_r};
  assign draw_mask = {mem_rdata, 56'd0} >> a_r[5:0];
  assign draw_old  = rowv_r[draw_y[4:0]] ? fb_rdata : 64'd0;
  assign sum9      = {1'b0, a_r} + {1'b0, b_r};
  assign bcd_prod  = a_r * 8'd205;
  assign bcd_h     = (a_r >= 8'd200) ? 8'd2 : ((a_r >= 8'd100) ? 8'd1 : 8'd0);
  assign bcd_rem   = (a_r >= 8'd200) ? (a_r - 8'd200) :
                     ((a_r >= 8'd100) ? (a_r - 8'd100) : a_r);
  assign in_exec   = (in_tuser == c8ic_pkg::REQ_EXEC) && !halt_r && !wait_r;
  assign row_bits  = (!exec_r && (req_r == c8ic_pkg::REQ_ROW) && rowv_r[row_r]) ?
                     fb_rdata : 64'd0;
  assign resp_st   = exec_r ? st_r :
                     (halt_r ? c8ic_pkg::ST_HALT :
                      (wait_r ? c8ic_pkg::ST_WAIT : c8ic_pkg::ST_OK));

  assign in_tready  = (state_r == c8ic_pkg::S_IDLE);
  assign out_tvalid = out_v_r;
  assign out_tdata  = out_d_r;

  c8ic_ram #(.WIDTH(8), .DEPTH(4096)) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  c8ic_ram #(.WIDTH(64), .DEPTH(32)) u_fb (
    .clk   (clk),
    .we    (fb_we),
    .waddr (fb_waddr),
    .wdata (fb_wdata),
    .re    (fb_re),
    .raddr (fb_raddr),
    .rdata (fb_rdata)
  );

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      c8ic_pkg::S_CLEAR:    if (clr_r == 12'hFFF) state_nxt = c8ic_pkg::S_IDLE;
      c8ic_pkg::S_IDLE: begin
        if (in_tvalid) begin
          state_nxt = in_exec ? c8ic_pkg::S_FETCH_HI : c8ic_pkg::S_MISC;
        end
      end
      c8ic_pkg::S_MISC:     state_nxt = c8ic_pkg::S_RESP;
      c8ic_pkg::S_FETCH_HI: state_nxt = c8ic_pkg::S_FETCH_LO;
      c8ic_pkg::S_FETCH_LO: state_nxt = c8ic_pkg::S_DECODE;
      c8ic_pkg::S_DECODE:   state_nxt = c8ic_pkg::S_OPB;
      c8ic_pkg::S_OPB:      state_nxt = c8ic_pkg::S_EXEC;
      c8ic_pkg::S_EXEC: begin
        state_nxt = c8ic_pkg::S_FIN;
        if (op_r[15:12] == c8ic_pkg::OPC_DRW) begin
          state_nxt = c8ic_pkg::S_DRAW_RD;
        end else if (op_r[15:12] == c8ic_pkg::OPC_MISC) begin
          if (op_kk == c8ic_pkg::KK_BCD) state_nxt = c8ic_pkg::S_BCD;
          if (op_kk == c8ic_pkg::KK_STR) state_nxt = c8ic_pkg::S_STORE;
          if (op_kk == c8ic_pkg::KK_LDR) state_nxt = c8ic_pkg::S_LOAD_RD;
        end
      end
      c8ic_pkg::S_DRAW_RD: begin
        state_nxt = ((cnt_r == op_n) || draw_y[5]) ? c8ic_pkg::S_FIN : c8ic_pkg::S_DRAW_WR;
      end
      c8ic_pkg::S_DRAW_WR:  state_nxt = c8ic_pkg::S_DRAW_RD;
      c8ic_pkg::S_BCD:      if (cnt_r == 4'd2) state_nxt = c8ic_pkg::S_FIN;
      c8ic_pkg::S_STORE:    if (cnt_r == op_x) state_nxt = c8ic_pkg::S_FIN;
      c8ic_pkg::S_LOAD_RD:  state_nxt = c8ic_pkg::S_LOAD_WR;
      c8ic_pkg::S_LOAD_WR: begin
        state_nxt = (cnt_r == op_x) ? c8ic_pkg::S_FIN : c8ic_pkg::S_LOAD_RD;
      end
      c8ic_pkg::S_FIN:      state_nxt = c8ic_pkg::S_RESP;
      c8ic_pkg::S_RESP:     if (!out_v_r || out_tready) state_nxt = c8ic_pkg::S_IDLE;
      default:              state_nxt = c8ic_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    clr_nxt    = clr_r;
    v_nxt      = v_r;
    stk_nxt    = stk_r;
    i_nxt      = i_r;
    pc_nxt     = pc_r;
    depth_nxt  = depth_r;
    dly_nxt    = dly_r;
    keys_nxt   = keys_r;
    wait_nxt   = wait_r;
    wtgt_nxt   = wtgt_r;
    halt_nxt   = halt_r;
    rowv_nxt   = rowv_r;
    op_nxt     = op_r;
    a_nxt      = a_r;
    b_nxt      = b_r;
    cnt_nxt    = cnt_r;
    st_nxt     = st_r;
    adv_nxt    = adv_r;
    exec_nxt   = exec_r;
    req_nxt    = req_r;
    key_nxt    = key_r;
    down_nxt   = down_r;
    ldaddr_nxt = ldaddr_r;
    ldbyte_nxt = ldbyte_r;
    rnd_nxt    = rnd_r;
    row_nxt    = row_r;
    out_v_nxt  = out_v_r;
    out_d_nxt  = out_d_r;
    mem_we     = 1'b0;
    mem_waddr  = i_off;
    mem_wdata  = 8'd0;
    mem_re     = 1'b0;
    mem_raddr  = i_off;
    fb_we      = 1'b0;
    fb_waddr   = draw_y[4:0];
    fb_wdata   = draw_old ^ draw_mask;
    fb_re      = 1'b0;
    fb_raddr   = draw_y[4:0];

    if (out_v_r && out_tready) begin
      out_v_nxt = 1'b0;
    end

    case (state_r)
      c8ic_pkg::S_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_r;
        mem_wdata = c8ic_pkg::font_byte(clr_r);
        clr_nxt   = clr_r + 12'd1;
      end
      c8ic_pkg::S_IDLE: begin
        if (in_tvalid) begin
          exec_nxt   = in_exec;
          req_nxt    = in_tuser;
          key_nxt    = in_tdata[3:0];
          down_nxt   = in_tdata[4];
          ldaddr_nxt = in_tdata[16:5];
          ldbyte_nxt = in_tdata[24:17];
          rnd_nxt    = in_tdata[32:25];
          row_nxt    = in_tdata[37:33];
          op_nxt     = 16'd0;
        end
      end
      c8ic_pkg::S_MISC: begin
        case (req_r)
          c8ic_pkg::REQ_TICK: if (dly_r != 8'd0) dly_nxt = dly_r - 8'd1;
          c8ic_pkg::REQ_KEY: begin
            if (down_r) begin
              keys_nxt[key_r] = 1'b1;
              if (wait_r) begin
                v_nxt[wtgt_r] = {4'd0, key_r};
                wait_nxt      = 1'b0;
                pc_nxt        = pc_r + 12'd2;
              end
            end else begin
              keys_nxt[key_r] = 1'b0;
            end
          end
          c8ic_pkg::REQ_LOAD: begin
            mem_we    = 1'b1;
            mem_waddr = ldaddr_r;
            mem_wdata = ldbyte_r;
          end
          c8ic_pkg::REQ_ROW: begin
            fb_re    = 1'b1;
            fb_raddr = row_r;
          end
          default: ;
        endcase
      end
      c8ic_pkg::S_FETCH_HI: begin
        mem_re    = 1'b1;
        mem_raddr = pc_r;
      end
      c8ic_pkg::S_FETCH_LO: begin
        mem_re       = 1'b1;
        mem_raddr    = pc_r + 12'd1;
        op_nxt[15:8] = mem_rdata;
      end
      c8ic_pkg::S_DECODE: begin
        op_nxt[7:0] = mem_rdata;
        a_nxt       = v_r[op_r[11:8]];
      end
      c8ic_pkg::S_OPB: b_nxt = v_r[op_y];
      c8ic_pkg::S_EXEC: begin
        st_nxt  = c8ic_pkg::ST_OK;
        adv_nxt = 3'd2;
        cnt_nxt = 4'd0;
        case (op_r[15:12])
          c8ic_pkg::OPC_SYS: begin
            if (op_r == c8ic_pkg::OP_CLS) begin
              rowv_nxt = 32'd0;
            end else if (op_r == c8ic_pkg::OP_RET) begin
              if (depth_r == 5'd0) begin
                st_nxt = c8ic_pkg::ST_STACK;
              end else begin
                depth_nxt = depth_dec;
                pc_nxt    = stk_r[depth_dec[3:0]];
              end
            end else begin
              st_nxt = c8ic_pkg::ST_NOIMPL;
            end
          end
          c8ic_pkg::OPC_JP: begin
            pc_nxt  = op_r[11:0];
            adv_nxt = 3'd0;
          end
          c8ic_pkg::OPC_CALL: begin
            if (depth_r[4]) begin
              st_nxt = c8ic_pkg::ST_STACK;
            end else begin
              stk_nxt[depth_r[3:0]] = pc_r;
              depth_nxt = depth_r + 5'd1;
              pc_nxt    = op_r[11:0];
              adv_nxt   = 3'd0;
            end
          end
          c8ic_pkg::OPC_SE:   if (a_r == op_kk) adv_nxt = 3'd4;
          c8ic_pkg::OPC_SNE:  if (a_r != op_kk) adv_nxt = 3'd4;
          c8ic_pkg::OPC_LDK:  v_nxt[op_x] = op_kk;
          c8ic_pkg::OPC_ADDK: v_nxt[op_x] = a_r + op_kk;
          c8ic_pkg::OPC_ALU: begin
            case (op_n)
              c8ic_pkg::ALU_LD:  v_nxt[op_x] = b_r;
              c8ic_pkg::ALU_AND: v_nxt[op_x] = a_r & b_r;
              c8ic_pkg::ALU_XOR: v_nxt[op_x] = a_r ^ b_r;
              c8ic_pkg::ALU_ADD: begin
                v_nxt[15]   = {7'd0, sum9[8]};
                v_nxt[op_x] = sum9[7:0];
              end
              c8ic_pkg::ALU_SUB: begin
                v_nxt[15]   = {7'd0, (a_r > b_r)};
                v_nxt[op_x] = a_r - b_r;
              end
              c8ic_pkg::ALU_SHL: begin
                v_nxt[15]   = {7'd0, a_r[7]};
                v_nxt[op_x] = {a_r[6:0], 1'b0};
              end
              default: st_nxt = c8ic_pkg::ST_NOIMPL;
            endcase
          end
          c8ic_pkg::OPC_LDI: i_nxt = {4'd0, op_r[11:0]};
          c8ic_pkg::OPC_RND: v_nxt[op_x] = rnd_r & op_kk;
          c8ic_pkg::OPC_DRW: v_nxt[15] = 8'd0;
          c8ic_pkg::OPC_KEY: begin
            if (op_kk == c8ic_pkg::KK_SKP) begin
              if (keys_r[a_r[3:0]]) adv_nxt = 3'd4;
            end else if (op_kk == c8ic_pkg::KK_SKNP) begin
              if (!keys_r[a_r[3:0]]) adv_nxt = 3'd4;
            end else begin
              st_nxt = c8ic_pkg::ST_NOIMPL;
            end
          end
          c8ic_pkg::OPC_MISC: begin
            case (op_kk)
              c8ic_pkg::KK_GDLY: v_nxt[op_x] = dly_r;
              c8ic_pkg::KK_WKEY: begin
                wait_nxt = 1'b1;
                wtgt_nxt = op_x;
                adv_nxt  = 3'd0;
                st_nxt   = c8ic_pkg::ST_WAIT;
              end
              c8ic_pkg::KK_SDLY: dly_nxt = a_r;
              c8ic_pkg::KK_SND:  ;
              c8ic_pkg::KK_ADDI: i_nxt = i_r + {8'd0, a_r};
              c8ic_pkg::KK_FONT: i_nxt = {10'd0, a_r[3:0], 2'd0} + {12'd0, a_r[3:0]};
              c8ic_pkg::KK_BCD:  ;
              c8ic_pkg::KK_STR:  ;
              c8ic_pkg::KK_LDR:  ;
              default: st_nxt = c8ic_pkg::ST_NOIMPL;
            endcase
          end
          default: st_nxt = c8ic_pkg::ST_NOIMPL;
        endcase
      end
      c8ic_pkg::S_DRAW_RD: begin
        if (!((cnt_r == op_n) || draw_y[5])) begin
          mem_re = 1'b1;
          fb_re  = 1'b1;
        end
      end
      c8ic_pkg::S_DRAW_WR: begin
        if ((draw_old & draw_mask) != 64'd0) v_nxt[15] = 8'd1;
        fb_we                = 1'b1;
        rowv_nxt[draw_y[4:0]] = 1'b1;
        cnt_nxt              = cnt_r + 4'd1;
      end
      c8ic_pkg::S_BCD: begin
        mem_we  = 1'b1;
        cnt_nxt = cnt_r + 4'd1;
        case (cnt_r)
          4'd0: begin
            mem_wdata = bcd_h;
            a_nxt     = bcd_rem;
          end
          4'd1: begin
            mem_wdata = {3'd0, bcd_prod[15:11]};
            b_nxt     = {3'd0, bcd_prod[15:11]};
          end
          default: mem_wdata = a_r - ({b_r[4:0], 3'd0} + {b_r[6:0], 1'b0});
        endcase
      end
      c8ic_pkg::S_STORE: begin
        mem_we    = 1'b1;
        mem_wdata = v_r[cnt_r];
        cnt_nxt   = cnt_r + 4'd1;
      end
      c8ic_pkg::S_LOAD_RD: mem_re = 1'b1;
      c8ic_pkg::S_LOAD_WR: begin
        v_nxt[cnt_r] = mem_rdata;
        cnt_nxt      = cnt_r + 4'd1;
      end
      c8ic_pkg::S_FIN: begin
        if ((st_r == c8ic_pkg::ST_NOIMPL) || (st_r == c8ic_pkg::ST_STACK)) begin
          halt_nxt = 1'b1;
        end else begin
          pc_nxt = pc_r + {9'd0, adv_r};
        end
      end
      c8ic_pkg::S_RESP: begin
        if (!out_v_r || out_tready) begin
          out_v_nxt = 1'b1;
          out_d_nxt = {1'b0, dly_r, row_bits, resp_st, op_r, pc_r};
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= c8ic_pkg::S_CLEAR;
      clr_r   <= 12'd0;
      for (int k = 0; k < 16; k++) v_r[k] <= 8'd0;
      i_r     <= 16'd0;
      pc_r    <= 12'd512;
      depth_r <= 5'd0;
      dly_r   <= 8'd0;
      keys_r  <= 16'd0;
      wait_r  <= 1'b0;
      wtgt_r  <= 4'd0;
      halt_r  <= 1'b0;
      rowv_r  <= 32'd0;
      out_v_r <= 1'b0;
      exec_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      clr_r   <= clr_nxt;
      v_r     <= v_nxt;
      i_r     <= i_nxt;
      pc_r    <= pc_nxt;
      depth_r <= depth_nxt;
      dly_r   <= dly_nxt;
      keys_r  <= keys_nxt;
      wait_r  <= wait_nxt;
      wtgt_r  <= wtgt_nxt;
      halt_r  <= halt_nxt;
      rowv_r  <= rowv_nxt;
      out_v_r <= out_v_nxt;
      exec_r  <= exec_nxt;
    end
  end

  always_ff @(posedge clk) begin
    stk_r    <= stk_nxt;
    op_r     <= op_nxt;
    a_r      <= a_nxt;
    b_r      <= b_nxt;
    cnt_r    <= cnt_nxt;
    st_r     <= st_nxt;
    adv_r    <= adv_nxt;
    req_r    <= req_nxt;
    key_r    <= key_nxt;
    down_r   <= down_nxt;
    ldaddr_r <= ldaddr_nxt;
    ldbyte_r <= ldbyte_nxt;
    rnd_r    <= rnd_nxt;
    row_r    <= row_nxt;
    out_d_r  <= out_d_nxt;
  end

`ifndef ASSERT_OFF
  a_depth_range: assert property (@(posedge clk) disable iff (!rst_n)
    depth_r <= 5'd16) else $error("return depth out of range");

  a_halt_wait: assert property (@(posedge clk) disable iff (!rst_n)
    !(halt_r && wait_r)) else $error("halted while waiting for a key");

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> (state_r != c8ic_pkg::S_IDLE))
    else $error("sequencer did not leave idle after a transfer");
`endif

endmodule
